// File: hdl/tvsp_pkg.sv
// Shared types, codes and constants for the tagged value stream parser.
// No dependencies; tvsp_front, tvsp_back and the top unit import this package.
package tvsp_pkg;

   // Default sizing
   localparam int LENGTH_BITS_DEF      = 32;
   localparam int MAX_NUMBER_BYTES_DEF = 10;
   localparam int MID_DEPTH_DEF        = 4;
   localparam int RSP_DEPTH_DEF        = 4;

   // Result event codes
   localparam logic [2:0] EV_BOOL       = 3'd0;
   localparam logic [2:0] EV_INT        = 3'd1;
   localparam logic [2:0] EV_TEXT_START = 3'd2;
   localparam logic [2:0] EV_TEXT_BYTE  = 3'd3;
   localparam logic [2:0] EV_BLOB_START = 3'd4;
   localparam logic [2:0] EV_BLOB_BYTE  = 3'd5;
   localparam logic [2:0] EV_END        = 3'd6;
   localparam logic [2:0] EV_ERROR      = 3'd7;

   // Error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_PREFIX    = 3'd1;
   localparam logic [2:0] ERR_TAG       = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_OVERLONG  = 3'd4;

   // Type tag bytes
   localparam logic [7:0] TAG_BYTE_BOOL = 8'h7D;
   localparam logic [7:0] TAG_BYTE_INT  = 8'h7C;
   localparam logic [7:0] TAG_BYTE_TEXT = 8'h71;
   localparam logic [7:0] TAG_BYTE_BLOB = 8'h68;
   localparam logic [7:0] BOOL_TRUE     = 8'h01;

   // Decoded tag class of a byte
   typedef enum logic [2:0] {
      TAG_BOOL,
      TAG_INT,
      TAG_TEXT,
      TAG_BLOB,
      TAG_NONE
   } tag_type;

   // Input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
   } req_item_type;

   // Result transaction
   typedef struct packed {
      logic [2:0]         event_res;
      logic signed [63:0] value;
      logic [2:0]         error_code;
      logic               message_done;
   } rsp_item_type;

   // Classified byte handed from front to back
   typedef struct packed {
      logic [7:0] data_byte;
      logic       final_byte;
      tag_type    tag;
      logic       cont;
      logic       sign;
      logic [6:0] grp;
      logic       is_true;
   } mid_item_type;

   // Expected prefix byte at a given position: "DIDL"
   function automatic logic [7:0] didl_mark(input logic [1:0] idx);
      logic [7:0] mark;
      unique case (idx)
         2'd0:    mark = 8'h44;
         2'd1:    mark = 8'h49;
         2'd2:    mark = 8'h44;
         default: mark = 8'h4C;
      endcase
      return mark;
   endfunction

endpackage

// File: hdl/tagged_value_stream_parser_unit.sv
// Tagged value stream parser: DIDL prefix check, LEB128 numbers, payload pass-through.
// Input transactions carry one message byte and a final-byte flag; pushed while
// req_full is low. Result transactions (event, value, error code, message_done)
// are read while rsp_empty is low and removed with rsp_pop. Each byte yields
// zero or one result.
// An accepted byte is stored in the middle queue, parsed by the back end as it
// leaves that queue, and its result is stored in the result queue, from which
// rsp_data shows it and rsp_pop removes it.
// Throughput: one byte per cycle while bytes wait and the result queue has room;
// the back end parses each byte combinationally (one shift-or and compares per byte).
// A front classifier feeds a MID_DEPTH queue; the back end writes an RSP_DEPTH
// result queue. When the receiver stalls, the result queue fills, the back end
// stops, the middle queue fills and req_full rises; nothing is lost.
// Reset (synchronous, active high) empties both queues and returns the parser
// to waiting for the prefix of a new message.
// Depends on tvsp_pkg, tvsp_front, tvsp_fifo and tvsp_back.
module tagged_value_stream_parser_unit
   import tvsp_pkg::*;
#(
   parameter int LENGTH_BITS      = LENGTH_BITS_DEF,
   parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF,
   parameter int MID_DEPTH        = MID_DEPTH_DEF,
   parameter int RSP_DEPTH        = RSP_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_item_type req_data,
   output logic         req_full,
   input  logic         rsp_pop,
   output rsp_item_type rsp_data,
   output logic         rsp_empty
);

   mid_item_type mid_in, mid_out;
   logic         mid_empty;
   logic         rsp_full;
   logic         back_go;
   logic         back_valid;
   rsp_item_type back_item;

   // Classify the byte on the way in
   tvsp_front u_front (
      .req_item (req_data),
      .mid_item (mid_in)
   );

   // Decoupling queue between front and back
   tvsp_fifo #(
      .WIDTH ($bits(mid_item_type)),
      .DEPTH (MID_DEPTH)
   ) u_mid_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (mid_in),
      .full      (req_full),
      .pop       (back_go),
      .pop_data  (mid_out),
      .empty     (mid_empty)
   );

   // Back end advances when a byte waits and a result slot is free
   assign back_go = !mid_empty && !rsp_full;

   tvsp_back #(
      .LENGTH_BITS      (LENGTH_BITS),
      .MAX_NUMBER_BYTES (MAX_NUMBER_BYTES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .go        (back_go),
      .mid_item  (mid_out),
      .rsp_valid (back_valid),
      .rsp_item  (back_item)
   );

   // Result queue
   tvsp_fifo #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_item),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

// File: hdl/tvsp_fifo.sv
// Small synchronous queue of flip-flops with first-word fall-through read.
// Depends on nothing; used between front and back and at the result side.
module tvsp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and count update with wrap at DEPTH
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage, no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/tvsp_front.sv
// Front end: classifies each incoming byte (tag class, LEB128 fields).
// Depends on tvsp_pkg; feeds the queue ahead of tvsp_back.
module tvsp_front
   import tvsp_pkg::*;
(
   input  req_item_type req_item,
   output mid_item_type mid_item
);

   // Tag decode
   always_comb begin
      unique case (req_item.data_byte)
         TAG_BYTE_BOOL: mid_item.tag = TAG_BOOL;
         TAG_BYTE_INT:  mid_item.tag = TAG_INT;
         TAG_BYTE_TEXT: mid_item.tag = TAG_TEXT;
         TAG_BYTE_BLOB: mid_item.tag = TAG_BLOB;
         default:       mid_item.tag = TAG_NONE;
      endcase
   end

   // LEB128 group fields and pass-through
   assign mid_item.data_byte  = req_item.data_byte;
   assign mid_item.final_byte = req_item.final_byte;
   assign mid_item.cont       = req_item.data_byte[7];
   assign mid_item.sign       = req_item.data_byte[6];
   assign mid_item.grp        = req_item.data_byte[6:0];
   assign mid_item.is_true    = (req_item.data_byte == BOOL_TRUE);

endmodule

// File: hdl/tvsp_back.sv
// Back end: the parse state machine, one classified byte per cycle while go is high.
// Depends on tvsp_pkg; reads the middle queue and writes the result queue.
module tvsp_back
   import tvsp_pkg::*;
#(
   parameter int LENGTH_BITS      = LENGTH_BITS_DEF,
   parameter int MAX_NUMBER_BYTES = MAX_NUMBER_BYTES_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         go,
   input  mid_item_type mid_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam logic [6:0] SHIFT_LIMIT = 7'(7 * MAX_NUMBER_BYTES);
   localparam logic [6:0] LEN_SHIFT   = 7'(LENGTH_BITS);

   typedef enum logic [2:0] {
      PH_PREFIX  = 3'd0,
      PH_TAG     = 3'd1,
      PH_BOOL    = 3'd2,
      PH_INT     = 3'd3,
      PH_LEN     = 3'd4,
      PH_PAYLOAD = 3'd5
   } phase_type;

   phase_type              phase_ff, phase_in;
   logic [1:0]             prefix_ff, prefix_in;
   logic                   blob_ff, blob_in;
   logic [63:0]            acc_ff, acc_in;
   logic [6:0]             shift_ff, shift_in;
   logic [LENGTH_BITS-1:0] left_ff, left_in;
   logic                   discard_ff, discard_in;

   logic [70:0]            wide;
   logic [6:0]             shift_next;
   logic [63:0]            acc_or;
   logic [LENGTH_BITS-1:0] left_dec;
   logic                   fin;
   logic                   emit, fail, restart;
   logic [2:0]             ev, err;
   logic [63:0]            val;

   assign fin        = mid_item.final_byte;
   assign wide       = {64'd0, mid_item.grp} << shift_ff;
   assign shift_next = shift_ff + 7'd7;
   assign acc_or     = acc_ff | wide[63:0];
   assign left_dec   = (left_ff != '0) ? left_ff - 1'b1 : left_ff;

   // Next-state and result decode
   always_comb begin
      phase_in   = phase_ff;
      prefix_in  = prefix_ff;
      blob_in    = blob_ff;
      acc_in     = acc_ff;
      shift_in   = shift_ff;
      left_in    = left_ff;
      discard_in = discard_ff;
      emit       = 1'b0;
      fail       = 1'b0;
      restart    = 1'b0;
      ev         = EV_END;
      err        = ERR_NONE;
      val        = '0;

      if (discard_ff) begin
         restart = fin;
      end else begin
         unique case (phase_ff)
            PH_PREFIX: begin
               if (mid_item.data_byte != didl_mark(prefix_ff)) begin
                  fail = 1'b1;
                  err  = ERR_PREFIX;
               end else if (prefix_ff == 2'd3) begin
                  prefix_in = '0;
                  phase_in  = PH_TAG;
                  if (fin) begin
                     emit = 1'b1;
                     ev   = EV_END;
                  end
               end else begin
                  prefix_in = prefix_ff + 1'b1;
                  if (fin) begin
                     fail = 1'b1;
                     err  = ERR_PREFIX;
                  end
               end
            end
            PH_TAG: begin
               acc_in   = '0;
               shift_in = '0;
               unique case (mid_item.tag)
                  TAG_BOOL: phase_in = PH_BOOL;
                  TAG_INT:  phase_in = PH_INT;
                  TAG_TEXT: begin
                     phase_in = PH_LEN;
                     blob_in  = 1'b0;
                  end
                  TAG_BLOB: begin
                     phase_in = PH_LEN;
                     blob_in  = 1'b1;
                  end
                  default: ;
               endcase
               if (mid_item.tag == TAG_NONE) begin
                  fail = 1'b1;
                  err  = ERR_TAG;
               end else if (fin) begin
                  fail = 1'b1;
                  err  = ERR_TRUNCATED;
               end
            end
            PH_BOOL: begin
               phase_in = PH_TAG;
               emit     = 1'b1;
               ev       = EV_BOOL;
               val      = {63'd0, mid_item.is_true};
            end
            PH_INT: begin
               if (shift_ff < 7'd64) begin
                  acc_in = acc_or;
               end
               if (mid_item.cont) begin
                  if (shift_next >= SHIFT_LIMIT) begin
                     fail = 1'b1;
                     err  = ERR_OVERLONG;
                  end else if (fin) begin
                     fail = 1'b1;
                     err  = ERR_TRUNCATED;
                  end else begin
                     shift_in = shift_next;
                  end
               end else begin
                  // sign-extend from bit 6 of the last group
                  if (shift_next < 7'd64 && mid_item.sign) begin
                     acc_in = acc_in | (~64'd0 << shift_next);
                  end
                  phase_in = PH_TAG;
                  emit     = 1'b1;
                  ev       = EV_INT;
                  val      = acc_in;
               end
            end
            PH_LEN: begin
               if (shift_ff >= LEN_SHIFT) begin
                  if (mid_item.grp != '0) begin
                     fail = 1'b1;
                     err  = ERR_OVERLONG;
                  end
               end else if (wide[70:LENGTH_BITS] != '0) begin
                  fail = 1'b1;
                  err  = ERR_OVERLONG;
               end else begin
                  acc_in = acc_or;
               end
               if (!fail) begin
                  if (mid_item.cont) begin
                     if (shift_next >= SHIFT_LIMIT) begin
                        fail = 1'b1;
                        err  = ERR_OVERLONG;
                     end else if (fin) begin
                        fail = 1'b1;
                        err  = ERR_TRUNCATED;
                     end else begin
                        shift_in = shift_next;
                     end
                  end else if (acc_in == '0) begin
                     phase_in = PH_TAG;
                     emit     = 1'b1;
                     ev       = blob_ff ? EV_BLOB_START : EV_TEXT_START;
                  end else if (fin) begin
                     fail = 1'b1;
                     err  = ERR_TRUNCATED;
                  end else begin
                     left_in  = acc_in[LENGTH_BITS-1:0];
                     phase_in = PH_PAYLOAD;
                     emit     = 1'b1;
                     ev       = blob_ff ? EV_BLOB_START : EV_TEXT_START;
                     val      = acc_in;
                  end
               end
            end
            PH_PAYLOAD: begin
               left_in = left_dec;
               if (left_dec != '0 && fin) begin
                  fail = 1'b1;
                  err  = ERR_TRUNCATED;
               end else begin
                  if (left_dec == '0) begin
                     phase_in = PH_TAG;
                  end
                  emit = 1'b1;
                  ev   = blob_ff ? EV_BLOB_BYTE : EV_TEXT_BYTE;
                  val  = {56'd0, mid_item.data_byte};
               end
            end
            default: restart = 1'b1;
         endcase

         // error handling: close the message or drop its remainder
         if (fail) begin
            emit = 1'b1;
            ev   = EV_ERROR;
            val  = '0;
            if (fin) begin
               restart = 1'b1;
            end else begin
               discard_in = 1'b1;
            end
         end else if (emit && fin) begin
            restart = 1'b1;
         end
      end

      if (restart) begin
         phase_in   = PH_PREFIX;
         prefix_in  = '0;
         blob_in    = 1'b0;
         acc_in     = '0;
         shift_in   = '0;
         left_in    = '0;
         discard_in = 1'b0;
      end
   end

   // Result toward the output queue
   assign rsp_valid             = go && emit;
   assign rsp_item.event_res    = ev;
   assign rsp_item.value        = val;
   assign rsp_item.error_code   = err;
   assign rsp_item.message_done = fin;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_PREFIX;
         prefix_ff  <= '0;
         blob_ff    <= 1'b0;
         acc_ff     <= '0;
         shift_ff   <= '0;
         left_ff    <= '0;
         discard_ff <= 1'b0;
      end else if (go) begin
         phase_ff   <= phase_in;
         prefix_ff  <= prefix_in;
         blob_ff    <= blob_in;
         acc_ff     <= acc_in;
         shift_ff   <= shift_in;
         left_ff    <= left_in;
         discard_ff <= discard_in;
      end
   end

endmodule

// File: sim/tvsp_event_checker.sv
`timescale 1ns / 100ps
// Event checker for the tagged value stream parser: predicts the result of each
// accepted input byte and compares each popped result against the oldest prediction.
// Depends on tvsp_pkg for the transaction types, event codes, error codes and tags.
module tvsp_event_checker
   import tvsp_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  req_item_type req_data,
   input  logic         req_full,
   input  logic         rsp_pop,
   input  rsp_item_type rsp_data,
   input  logic         rsp_empty,
   output int           pending_count,
   output int           checked_count,
   output int           failure_count
);

   localparam int          LEN_LIMIT   = LENGTH_BITS_DEF;
   localparam int          RUN_LIMIT   = 7 * MAX_NUMBER_BYTES_DEF;
   localparam logic [31:0] PREFIX_WORD = "DIDL";

   typedef enum logic [2:0] {
      AT_PREFIX,
      AT_TAG,
      AT_BOOL,
      AT_INT,
      AT_LENGTH,
      AT_PAYLOAD
   } parse_phase_type;

   // Predicted parser state
   parse_phase_type phase;
   logic [1:0]      prefix_pos;
   tag_type         cur_tag;
   logic [63:0]     accum;
   int unsigned     bit_pos;
   logic [63:0]     remaining;
   bit              dropping;

   rsp_item_type    expected_events[$];

   task automatic restart_parser();
      phase      = AT_PREFIX;
      prefix_pos = '0;
      cur_tag    = TAG_BOOL;
      accum      = '0;
      bit_pos    = 0;
      remaining  = '0;
      dropping   = 1'b0;
   endtask

   task automatic emit_result(input logic [2:0] ev, input logic [63:0] val,
                              input logic [2:0] code, input logic done);
      rsp_item_type r;
      r.event_res    = ev;
      r.value        = val;
      r.error_code   = code;
      r.message_done = done;
      expected_events.insert(expected_events.size(), r);
   endtask

   // Error result; a non-final error drops the rest of the message
   task automatic flag_error(input logic [2:0] code, input logic fin);
      emit_result(EV_ERROR, '0, code, fin);
      if (fin) restart_parser();
      else dropping = 1'b1;
   endtask

   // Finished value; a final byte also closes the message
   task automatic close_value(input logic [2:0] ev, input logic [63:0] val, input logic fin);
      emit_result(ev, val, ERR_NONE, fin);
      if (fin) restart_parser();
   endtask

   // One step of the parser for one accepted byte
   task automatic parse_byte(input req_item_type item);
      logic [7:0]  b;
      logic        fin;
      logic [63:0] grp;
      int unsigned pos;
      logic [7:0]  mark;
      logic [2:0]  start_ev;
      logic [2:0]  byte_ev;
      b   = item.data_byte;
      fin = item.final_byte;
      grp = {57'd0, b[6:0]};
      pos = bit_pos;
      if (dropping) begin
         if (fin) restart_parser();
         return;
      end
      case (phase)
         AT_PREFIX: begin
            mark = PREFIX_WORD[8 * (3 - int'(prefix_pos)) +: 8];
            if (b != mark) begin
               flag_error(ERR_PREFIX, fin);
               return;
            end
            if (prefix_pos == 2'd3) begin
               prefix_pos = '0;
               phase      = AT_TAG;
            end else begin
               prefix_pos++;
            end
            if (fin) begin
               // a bare prefix is an empty message
               if (phase == AT_TAG) close_value(EV_END, '0, 1'b1);
               else flag_error(ERR_PREFIX, 1'b1);
            end
         end
         AT_TAG: begin
            accum   = '0;
            bit_pos = 0;
            case (b)
               TAG_BYTE_BOOL: begin
                  cur_tag = TAG_BOOL;
                  phase   = AT_BOOL;
               end
               TAG_BYTE_INT: begin
                  cur_tag = TAG_INT;
                  phase   = AT_INT;
               end
               TAG_BYTE_TEXT: begin
                  cur_tag = TAG_TEXT;
                  phase   = AT_LENGTH;
               end
               TAG_BYTE_BLOB: begin
                  cur_tag = TAG_BLOB;
                  phase   = AT_LENGTH;
               end
               default: begin
                  flag_error(ERR_TAG, fin);
                  return;
               end
            endcase
            if (fin) flag_error(ERR_TRUNCATED, 1'b1);
         end
         AT_BOOL: begin
            phase = AT_TAG;
            close_value(EV_BOOL, (b == BOOL_TRUE) ? 64'd1 : 64'd0, fin);
         end
         AT_INT: begin
            // groups beyond bit 63 are dropped
            if (pos < 64) accum |= grp << pos;
            pos += 7;
            if (b[7]) begin
               if (pos >= RUN_LIMIT) flag_error(ERR_OVERLONG, fin);
               else if (fin) flag_error(ERR_TRUNCATED, 1'b1);
               else bit_pos = pos;
               return;
            end
            // sign extension from the last group
            if (pos < 64 && b[6]) accum |= ~64'd0 << pos;
            phase = AT_TAG;
            close_value(EV_INT, accum, fin);
         end
         AT_LENGTH: begin
            start_ev = (cur_tag == TAG_TEXT) ? EV_TEXT_START : EV_BLOB_START;
            if (pos >= LEN_LIMIT) begin
               if (grp != 0) begin
                  flag_error(ERR_OVERLONG, fin);
                  return;
               end
            end else begin
               if ((grp >> (LEN_LIMIT - pos)) != 0) begin
                  flag_error(ERR_OVERLONG, fin);
                  return;
               end
               accum |= grp << pos;
            end
            pos += 7;
            if (b[7]) begin
               if (pos >= RUN_LIMIT) flag_error(ERR_OVERLONG, fin);
               else if (fin) flag_error(ERR_TRUNCATED, 1'b1);
               else bit_pos = pos;
               return;
            end
            if (accum == 0) begin
               phase = AT_TAG;
               close_value(start_ev, '0, fin);
            end else if (fin) begin
               flag_error(ERR_TRUNCATED, 1'b1);
            end else begin
               remaining = accum;
               phase     = AT_PAYLOAD;
               emit_result(start_ev, remaining, ERR_NONE, 1'b0);
            end
         end
         AT_PAYLOAD: begin
            byte_ev = (cur_tag == TAG_TEXT) ? EV_TEXT_BYTE : EV_BLOB_BYTE;
            if (remaining != 0) remaining--;
            if (remaining == 0) begin
               phase = AT_TAG;
               close_value(byte_ev, {56'd0, b}, fin);
            end else if (fin) begin
               flag_error(ERR_TRUNCATED, 1'b1);
            end else begin
               emit_result(byte_ev, {56'd0, b}, ERR_NONE, 1'b0);
            end
         end
         default: restart_parser();
      endcase
   endtask

   task automatic report_mismatch(input string what, input rsp_item_type got,
                                  input rsp_item_type want);
      $display("%0t mismatch (%s) at result %0d: got ev=%0d val=%0h err=%0d done=%0b,",
               $realtime, what, checked_count, got.event_res, got.value,
               got.error_code, got.message_done,
               " want ev=%0d val=%0h err=%0d done=%0b",
               want.event_res, want.value, want.error_code, want.message_done);
      failure_count++;
   endtask

   task automatic check_result(input rsp_item_type got);
      rsp_item_type want;
      if (expected_events.size() == 0) begin
         report_mismatch("nothing expected", got, got);
         return;
      end
      want = expected_events.pop_front();
      if (got.event_res !== want.event_res)       report_mismatch("event", got, want);
      if (got.value !== want.value)               report_mismatch("value", got, want);
      if (got.error_code !== want.error_code)     report_mismatch("error code", got, want);
      if (got.message_done !== want.message_done) report_mismatch("message done", got, want);
      checked_count++;
   endtask

   // Channel monitor: compare popped transactions, predict pushed ones
   always @(posedge clock) begin
      if (reset) begin
         restart_parser();
         expected_events.delete();
         checked_count = 0;
         failure_count = 0;
      end else begin
         if (rsp_pop && !rsp_empty) check_result(rsp_data);
         if (req_push && !req_full) parse_byte(req_data);
      end
      pending_count <= expected_events.size();
   end

endmodule

// File: sim/tb_tagged_value_stream_parser_unit.sv
`timescale 1ns / 100ps
// Top testbench for the tagged value stream parser: builds DIDL messages, drives
// the byte channel, pops results under varying idle patterns and gives the verdict.
// Depends on tvsp_pkg, tagged_value_stream_parser_unit and tvsp_event_checker.
module tb_tagged_value_stream_parser_unit
   import tvsp_pkg::*;
();

   localparam int          ITEMS_PER_PHASE = 300;
   localparam int          CYCLE_LIMIT     = 200000;
   localparam int          DRAIN_CYCLES    = 20;
   localparam logic [31:0] PREFIX_WORD     = "DIDL";
   localparam int          SEND_IDLE[4]    = '{0, 61, 0, 9};
   localparam int          RECV_STALL[4]   = '{0, 0, 61, 9};
   localparam logic [63:0] INT_EXTREMES[4] = '{64'h8000_0000_0000_0000,
                                               64'h7FFF_FFFF_FFFF_FFFF,
                                               64'h0, 64'hFFFF_FFFF_FFFF_FFFF};

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_push  = 1'b0;
   req_item_type req_data  = '0;
   logic         req_full;
   logic         rsp_pop   = 1'b0;
   rsp_item_type rsp_data;
   logic         rsp_empty;

   int           pending_count;
   int           checked_count;
   int           failure_count;
   int           send_idle_pct = 0;
   int           stall_pct     = 0;
   int           cycle_count   = 0;
   int           bytes_sent    = 0;
   int           messages_sent = 0;
   logic [7:0]   message[$];

   tagged_value_stream_parser_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_data  (req_data),
      .req_full  (req_full),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data),
      .rsp_empty (rsp_empty)
   );

   tvsp_event_checker checker_inst (
      .clock         (clock),
      .reset         (reset),
      .req_push      (req_push),
      .req_data      (req_data),
      .req_full      (req_full),
      .rsp_pop       (rsp_pop),
      .rsp_data      (rsp_data),
      .rsp_empty     (rsp_empty),
      .pending_count (pending_count),
      .checked_count (checked_count),
      .failure_count (failure_count)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Receiver with random stalls
   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(99) >= stall_pct);
   end

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results still expected",
                  cycle_count, pending_count);
         $display("tb_tagged_value_stream_parser_unit: errors");
         $finish;
      end
   end

   // Append one byte to the message under construction
   task automatic append_byte(input logic [7:0] b);
      message.insert(message.size(), b);
   endtask

   task automatic add_prefix();
      for (int i = 0; i < 4; i++) append_byte(PREFIX_WORD[8 * (3 - i) +: 8]);
   endtask

   // Minimal signed LEB128
   task automatic add_signed(input logic signed [63:0] v);
      logic [7:0] b;
      bit         more;
      do begin
         b    = {1'b0, v[6:0]};
         v    = v >>> 7;
         more = !((v == 0 && !b[6]) || (v == -1 && b[6]));
         if (more) b[7] = 1'b1;
         append_byte(b);
      end while (more);
   endtask

   // Unsigned LEB128 with optional redundant zero groups
   task automatic add_unsigned(input logic [63:0] v, input int pad);
      logic [7:0] b;
      do begin
         b = {1'b0, v[6:0]};
         v = v >> 7;
         if (v != 0 || pad > 0) b[7] = 1'b1;
         append_byte(b);
      end while (v != 0);
      while (pad > 0) begin
         pad--;
         append_byte((pad > 0) ? 8'h80 : 8'h00);
      end
   endtask

   task automatic add_int();
      int n;
      case ($urandom_range(3))
         0: add_signed({$urandom, $urandom});
         1: add_signed(int'($urandom_range(255)) - 128);
         2: begin
            // raw groups: exercises padding, sign bit and dropped high bits
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) append_byte({i < n - 1, 7'($urandom)});
         end
         default: add_signed(INT_EXTREMES[$urandom_range(3)]);
      endcase
   endtask

   task automatic add_value();
      int len;
      case ($urandom_range(3))
         0: begin
            append_byte(TAG_BYTE_BOOL);
            append_byte($urandom_range(1) ? BOOL_TRUE : 8'($urandom));
         end
         1: begin
            append_byte(TAG_BYTE_INT);
            add_int();
         end
         default: begin
            append_byte($urandom_range(1) ? TAG_BYTE_TEXT : TAG_BYTE_BLOB);
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            add_unsigned(len, ($urandom_range(7) == 0) ? $urandom_range(1, 9) : 0);
            repeat (len) append_byte(8'($urandom));
         end
      endcase
   endtask

   // Mostly well-formed messages; the rest carry one flaw
   task automatic build_message();
      int         flaw;
      int         keep;
      logic [7:0] bad_tag;
      message.delete();
      flaw = ($urandom_range(99) < 75) ? 0 : $urandom_range(1, 6);
      add_prefix();
      repeat ($urandom_range(0, 5)) add_value();
      case (flaw)
         1: message[$urandom_range(3)] ^= 8'($urandom_range(1, 255));
         2: begin
            do bad_tag = 8'($urandom);
            while (bad_tag == TAG_BYTE_BOOL || bad_tag == TAG_BYTE_INT ||
                   bad_tag == TAG_BYTE_TEXT || bad_tag == TAG_BYTE_BLOB);
            append_byte(bad_tag);
            repeat ($urandom_range(0, 2)) add_value();
         end
         3: begin
            // cut short anywhere, the prefix included
            keep = $urandom_range(1, message.size() - 1);
            while (message.size() > keep) void'(message.pop_back());
         end
         4: begin
            // continuation run that never stops
            append_byte($urandom_range(1) ? TAG_BYTE_INT : TAG_BYTE_TEXT);
            repeat ($urandom_range(10, 12)) append_byte(8'h80 | 8'($urandom));
         end
         5: begin
            // length too wide, or huge length with too little payload
            append_byte($urandom_range(1) ? TAG_BYTE_TEXT : TAG_BYTE_BLOB);
            add_unsigned({$urandom, $urandom} >> $urandom_range(0, 40), 0);
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
         end
         6: begin
            message.delete();
            repeat ($urandom_range(1, 8)) append_byte(8'($urandom));
         end
         default: ;
      endcase
   endtask

   task automatic send_item(input req_item_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full) @(posedge clock);
   endtask

   task automatic send_message();
      req_item_type item;
      for (int i = 0; i < message.size(); i++) begin
         item.data_byte  = message[i];
         item.final_byte = (i == message.size() - 1);
         send_item(item);
         bytes_sent++;
      end
      messages_sent++;
   endtask

   // Stimulus and verdict
   initial begin
      int phase_start;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty message: prefix alone
      message.delete();
      add_prefix();
      send_message();
      // every value kind, true and false bool, int -1, empty text, one-byte blob
      message.delete();
      add_prefix();
      append_byte(TAG_BYTE_BOOL);
      append_byte(BOOL_TRUE);
      append_byte(TAG_BYTE_BOOL);
      append_byte(8'hFF);
      append_byte(TAG_BYTE_INT);
      append_byte(8'h7F);
      append_byte(TAG_BYTE_TEXT);
      append_byte(8'h00);
      append_byte(TAG_BYTE_BLOB);
      append_byte(8'h01);
      append_byte(8'hFF);
      send_message();
      // wrong first byte that is also final
      message.delete();
      append_byte(8'h00);
      send_message();
      // message ending inside the prefix
      message.delete();
      add_prefix();
      void'(message.pop_back());
      void'(message.pop_back());
      send_message();
      // unknown tag, then a byte that must be dropped
      message.delete();
      add_prefix();
      append_byte(8'h33);
      append_byte(8'h00);
      send_message();

      // random messages under each idle pattern
      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct     = RECV_STALL[p];
         phase_start   = bytes_sent;
         while (bytes_sent - phase_start < ITEMS_PER_PHASE) begin
            build_message();
            send_message();
         end
      end
      req_push <= 1'b0;

      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("sent %0d messages (%0d bytes), checked %0d results", messages_sent,
               bytes_sent, checked_count);
      $display("covered well-formed and flawed messages with no idling, sender gaps,");
      $display("receiver stalls and both at once");
      if (failure_count == 0) begin
         $display("tb_tagged_value_stream_parser_unit: clean");
      end else begin
         $display("tb_tagged_value_stream_parser_unit: errors");
      end
      $finish;
   end

endmodule

// File: filelist.f
hdl/tvsp_pkg.sv
hdl/tvsp_fifo.sv
hdl/tvsp_front.sv
hdl/tvsp_back.sv
hdl/tagged_value_stream_parser_unit.sv
sim/tvsp_event_checker.sv
sim/tb_tagged_value_stream_parser_unit.sv
